// ===== rtl/core/mi3_pkg.sv =====
// Shared constants and index helpers for the 3x3 matrix inverse unit.
`default_nettype none
package mi3_pkg;
	localparam int DIM      = 3;
	localparam int ENTRY_W  = 32;
	localparam int ROW_W    = 2;
	localparam int IDX_W    = 4;

	// (a + b) mod 3 for row/column indexes 0..2
	function automatic logic [ROW_W-1:0] add_mod3(input logic [ROW_W-1:0] a,
			input logic [ROW_W-1:0] b);
		logic [ROW_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= 3'(DIM)) begin
			s = s - 3'(DIM);
		end
		return s[ROW_W-1:0];
	endfunction

	// row-major index of (r, c)
	function automatic logic [IDX_W-1:0] idx3(input logic [ROW_W-1:0] r,
			input logic [ROW_W-1:0] c);
		return IDX_W'(r) * IDX_W'(DIM) + IDX_W'(c);
	endfunction
endpackage
`default_nettype wire

// ===== rtl/core/mi3_if.sv =====
// Valid/ready channels for matrix rows in and inverse rows out.
`default_nettype none
interface mi3_row_if import mi3_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ENTRY_W-1:0]  entry_col0;
	logic signed [ENTRY_W-1:0]  entry_col1;
	logic signed [ENTRY_W-1:0]  entry_col2;
	modport source (output valid, entry_col0, entry_col1, entry_col2, input ready);
	modport sink (input valid, entry_col0, entry_col1, entry_col2, output ready);
endinterface

interface mi3_inv_if import mi3_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [ENTRY_W-1:0]  inv_col0;
	logic signed [ENTRY_W-1:0]  inv_col1;
	logic signed [ENTRY_W-1:0]  inv_col2;
	logic [ROW_W-1:0]           out_row;
	logic                       last;
	logic                       singular;
	logic                       saturated;
	modport source (output valid, inv_col0, inv_col1, inv_col2, out_row, last,
		singular, saturated, input ready);
	modport sink (input valid, inv_col0, inv_col1, inv_col2, out_row, last,
		singular, saturated, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/matrix_inverse_3x3_unit.sv =====
// 3x3 matrix inverse by adjugate over determinant, signed fixed point.
// Usage:
//   rows (sink): three items, matrix rows 0, 1, 2 in order, signed
//   fixed-point entries with FRAC_BITS fraction bits. Ready is high only
//   while the unit waits for rows; one row per cycle is taken then.
//   inverse (source): after the third row, three items, inverse rows
//   0..2, with out_row, last on row 2, singular when the determinant is
//   zero (all entries zero) and saturated when an entry was clipped.
// Datapath:
//   One 33x33 multiplier builds 18 cofactor products and 6 determinant
//   partial products, each read, multiplied and accumulated in turn, then
//   one restoring divider computes the 9 entries one after another. The
//   unit takes no new matrix while it works on one. The next matrix is
//   taken right after row 2 is loaded into the output register. A singular
//   matrix skips the divider; an entry that clips early skips it too.
// Stall: a row held by a stalled receiver keeps its register; the divider
//   finishes the next row and waits for the output register to free.
// Reset: the row count and all control clear; the matrix store does not.
`default_nettype none
module matrix_inverse_3x3_unit import mi3_pkg::*; #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mi3_row_if.sink   rows,
	mi3_inv_if.source inverse
);
	localparam int COF_W = 65;               // exact cofactor
	localparam int DET_W = 98;               // exact determinant
	localparam int PRD_W = 66;               // 33x33 product
	localparam int OPW   = 33;
	localparam int QW    = 33;               // quotient bits before rounding
	localparam int NW    = 64 + 2 * FRAC_BITS;
	localparam int CW    = $clog2(QW);

	typedef enum logic [3:0] {
		S_IDLE, S_RD_A, S_MUL, S_ACC, S_DV_PREP, S_DV_INIT, S_DV_STEP, S_DV_RND, S_PUT
	} state_t;

	state_t                     state_q;
	logic signed [ENTRY_W-1:0]  store_q [DIM*DIM];
	logic [ROW_W-1:0]           rows_q;
	logic                       det_phase_q;
	logic [ROW_W-1:0]           r_q, c_q;
	logic                       term_q;
	logic signed [OPW-1:0]      opa_q;
	logic signed [PRD_W-1:0]    prod_q;
	logic signed [COF_W-1:0]    cof_q [DIM*DIM];
	logic signed [DET_W-1:0]    det_q;
	logic [DET_W-1:0]           dmag_q;
	logic                       det_neg_q, sing_q, neg_q, sat_q;
	logic [ROW_W-1:0]           krow_q, kcol_q;
	logic [DET_W-1:0]           rem_q;
	logic [QW-1:0]              nlo_q, quo_q;
	logic [CW-1:0]              cnt_q;
	logic signed [ENTRY_W-1:0]  res_q [DIM];
	logic                       ov_q;
	logic signed [ENTRY_W-1:0]  o_col0_q, o_col1_q, o_col2_q;
	logic [ROW_W-1:0]           o_row_q;
	logic                       o_last_q, o_sing_q, o_sat_q;

	logic [IDX_W-1:0]           st_ra, cof_ra;
	logic signed [ENTRY_W-1:0]  st_rd;
	logic signed [COF_W-1:0]    cof_rd;
	logic signed [OPW-1:0]      opb;
	logic [63:0]                cmag;
	logic [NW-1:0]              num;
	logic [DET_W-1:0]           r0;
	logic [DET_W:0]             trial;
	logic                       fits;
	logic                       rnd;
	logic [QW:0]                qr;
	logic                       over;
	logic [ENTRY_W-1:0]         qval;
	logic [ENTRY_W-1:0]         limit;
	logic                       put_ok;

	// store read address: first operand in S_RD_A, second in S_MUL
	always_comb begin
		if (det_phase_q) begin
			st_ra = idx3(2'd0, c_q);
		end else if (state_q == S_RD_A) begin
			st_ra = term_q ? idx3(add_mod3(r_q, 2'd1), add_mod3(c_q, 2'd2))
			               : idx3(add_mod3(r_q, 2'd1), add_mod3(c_q, 2'd1));
		end else begin
			st_ra = term_q ? idx3(add_mod3(r_q, 2'd2), add_mod3(c_q, 2'd1))
			               : idx3(add_mod3(r_q, 2'd2), add_mod3(c_q, 2'd2));
		end
	end
	assign st_rd = store_q[st_ra];

	always_comb begin
		if (state_q == S_DV_INIT) begin
			cof_ra = idx3(kcol_q, krow_q);   // transposed
		end else if (det_phase_q) begin
			cof_ra = idx3(2'd0, c_q);
		end else begin
			cof_ra = idx3(r_q, c_q);
		end
	end
	assign cof_rd = cof_q[cof_ra];

	always_comb begin
		if (!det_phase_q) begin
			opb = OPW'(st_rd);
		end else if (term_q) begin
			opb = cof_rd[COF_W-1:32];
		end else begin
			opb = signed'({1'b0, cof_rd[31:0]});
		end
	end

	// divider datapath
	assign cmag  = cof_rd[COF_W-1] ? 64'(-cof_rd) : 64'(cof_rd);
	assign num   = {cmag, {(2*FRAC_BITS){1'b0}}};
	assign r0    = DET_W'(num[NW-1:QW]);
	assign trial = {rem_q, nlo_q[QW-1]};
	assign fits  = trial >= {1'b0, dmag_q};
	assign rnd   = {rem_q, 1'b0} >= {1'b0, dmag_q};
	assign qr    = {1'b0, quo_q} + (QW+1)'(rnd);
	assign limit = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
	assign over  = qr > (QW+1)'(limit);
	assign qval  = over ? limit : (neg_q ? (32'd0 - qr[ENTRY_W-1:0]) : qr[ENTRY_W-1:0]);
	assign put_ok = !ov_q || inverse.ready;

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && rows.valid) begin
			store_q[idx3(rows_q, 2'd0)] <= rows.entry_col0;
			store_q[idx3(rows_q, 2'd1)] <= rows.entry_col1;
			store_q[idx3(rows_q, 2'd2)] <= rows.entry_col2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rows_q      <= '0;
			det_phase_q <= 1'b0;
			r_q         <= '0;
			c_q         <= '0;
			term_q      <= 1'b0;
			krow_q      <= '0;
			kcol_q      <= '0;
			cnt_q       <= '0;
			sat_q       <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			// a new row loads the output register even as the old one drains
			if (state_q == S_PUT && put_ok) begin
				ov_q <= 1'b1;
			end else if (ov_q && inverse.ready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (rows.valid) begin
						if (rows_q == 2'd2) begin
							rows_q      <= '0;
							det_phase_q <= 1'b0;
							r_q         <= '0;
							c_q         <= '0;
							term_q      <= 1'b0;
							state_q     <= S_RD_A;
						end else begin
							rows_q <= rows_q + 2'd1;
						end
					end
				end
				S_RD_A: begin
					opa_q   <= OPW'(st_rd);
					state_q <= S_MUL;
				end
				S_MUL: begin
					prod_q  <= opa_q * opb;
					state_q <= S_ACC;
				end
				S_ACC: begin
					state_q <= S_RD_A;
					term_q  <= !term_q;
					if (!det_phase_q) begin
						if (!term_q) begin
							cof_q[cof_ra] <= COF_W'(prod_q);
						end else begin
							cof_q[cof_ra] <= cof_rd - COF_W'(prod_q);
							if (c_q == 2'd2) begin
								c_q <= '0;
								if (r_q == 2'd2) begin
									det_phase_q <= 1'b1;
									det_q       <= '0;
								end else begin
									r_q <= r_q + 2'd1;
								end
							end else begin
								c_q <= c_q + 2'd1;
							end
						end
					end else begin
						if (!term_q) begin
							det_q <= det_q + DET_W'(prod_q);
						end else begin
							det_q <= det_q + (DET_W'(prod_q) <<< 32);
							if (c_q == 2'd2) begin
								state_q <= S_DV_PREP;
							end else begin
								c_q <= c_q + 2'd1;
							end
						end
					end
				end
				S_DV_PREP: begin
					det_phase_q <= 1'b0;
					sing_q      <= (det_q == '0);
					det_neg_q   <= det_q[DET_W-1];
					dmag_q      <= det_q[DET_W-1] ? DET_W'(-det_q) : DET_W'(det_q);
					krow_q      <= '0;
					kcol_q      <= '0;
					sat_q       <= 1'b0;
					state_q     <= S_DV_INIT;
				end
				S_DV_INIT: begin
					neg_q <= cof_rd[COF_W-1] ^ det_neg_q;
					if (sing_q) begin
						res_q[kcol_q] <= '0;
						kcol_q        <= (kcol_q == 2'd2) ? kcol_q : kcol_q + 2'd1;
						state_q       <= (kcol_q == 2'd2) ? S_PUT : S_DV_INIT;
					end else if (r0 >= dmag_q) begin
						// quotient at least 2^33: clip without dividing
						sat_q         <= 1'b1;
						res_q[kcol_q] <= (cof_rd[COF_W-1] ^ det_neg_q) ? 32'sh8000_0000
						                                                : 32'sh7FFF_FFFF;
						kcol_q        <= (kcol_q == 2'd2) ? kcol_q : kcol_q + 2'd1;
						state_q       <= (kcol_q == 2'd2) ? S_PUT : S_DV_INIT;
					end else begin
						rem_q   <= r0;
						nlo_q   <= num[QW-1:0];
						quo_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DV_STEP;
					end
				end
				S_DV_STEP: begin
					rem_q <= fits ? DET_W'(trial - {1'b0, dmag_q}) : trial[DET_W-1:0];
					quo_q <= {quo_q[QW-2:0], fits};
					nlo_q <= {nlo_q[QW-2:0], 1'b0};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(QW-1)) begin
						state_q <= S_DV_RND;
					end
				end
				S_DV_RND: begin
					res_q[kcol_q] <= signed'(qval);
					if (over) begin
						sat_q <= 1'b1;
					end
					kcol_q  <= (kcol_q == 2'd2) ? kcol_q : kcol_q + 2'd1;
					state_q <= (kcol_q == 2'd2) ? S_PUT : S_DV_INIT;
				end
				S_PUT: begin
					if (put_ok) begin
						o_col0_q <= res_q[0];
						o_col1_q <= res_q[1];
						o_col2_q <= res_q[2];
						o_row_q  <= krow_q;
						o_last_q <= (krow_q == 2'd2);
						o_sing_q <= sing_q;
						o_sat_q  <= sat_q;
						sat_q    <= 1'b0;
						kcol_q   <= '0;
						if (krow_q == 2'd2) begin
							state_q <= S_IDLE;
						end else begin
							krow_q  <= krow_q + 2'd1;
							state_q <= S_DV_INIT;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rows.ready        = (state_q == S_IDLE);
	assign inverse.valid     = ov_q;
	assign inverse.inv_col0  = o_col0_q;
	assign inverse.inv_col1  = o_col1_q;
	assign inverse.inv_col2  = o_col2_q;
	assign inverse.out_row   = o_row_q;
	assign inverse.last      = o_last_q;
	assign inverse.singular  = o_sing_q;
	assign inverse.saturated = o_sat_q;

	a_row_idx: assert property (@(posedge clk) disable iff (!arst_n)
		inverse.valid |-> (inverse.last == (inverse.out_row == 2'd2)))
		else $error("last does not match row index");
	a_sing_zero: assert property (@(posedge clk) disable iff (!arst_n)
		inverse.valid && inverse.singular |-> inverse.inv_col0 == 0 &&
			inverse.inv_col1 == 0 && inverse.inv_col2 == 0 && !inverse.saturated)
		else $error("singular row carries data");
	a_rows_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		rows_q != 2'd3)
		else $error("row count out of range");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DV_STEP |-> cnt_q <= CW'(QW-1))
		else $error("divider ran too long");
	a_put_row: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PUT && put_ok |=> inverse.valid)
		else $error("row not presented");
endmodule
`default_nettype wire
